// ----- rtl/dq_pkg.sv -----
package dq_pkg;

	localparam int DEPTH      = 256;
	localparam int DATA_WIDTH = 32;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam int OP_FIELD_W    = 3;
	localparam int DATA_FIELD_W  = 32;
	localparam int POS_FIELD_W   = 8;
	localparam int STAT_FIELD_W  = 2;
	localparam int COUNT_FIELD_W = 9;

	localparam int OFS_W = ((CNT_W > POS_FIELD_W) ? CNT_W : POS_FIELD_W) + 1;

	typedef enum logic [OP_FIELD_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5,
		OP_READ_AT    = 3'd6
	} op_t;

	typedef enum logic [STAT_FIELD_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                  we;
		logic                  re;
		logic [ADDR_W-1:0]     addr;
		logic [DATA_WIDTH-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		status_t            status;
		logic               rd;
		logic [CNT_W-1:0]   count;
	} op_res_t;

	// Adds an offset below DEPTH to a slot index and wraps once.
	function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] base,
			logic [OFS_W-1:0] ofs);
		logic [OFS_W:0] sum;
		sum = (OFS_W+1)'(base) + (OFS_W+1)'(ofs);
		if (sum >= (OFS_W+1)'(DEPTH)) begin
			sum = sum - (OFS_W+1)'(DEPTH);
		end
		return ADDR_W'(sum);
	endfunction

endpackage

// ----- rtl/dq_if.sv -----
interface dq_req_if;
	import dq_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_FIELD_W-1:0]   op;
	logic [DATA_FIELD_W-1:0] value;
	logic [POS_FIELD_W-1:0]  position;

	modport source (output valid, op, value, position, input ready);
	modport sink (input valid, op, value, position, output ready);
endinterface

interface dq_rsp_if;
	import dq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [DATA_FIELD_W-1:0]  data;
	logic [STAT_FIELD_W-1:0]  status;
	logic [COUNT_FIELD_W-1:0] count;
	logic                     is_empty;
	logic                     is_full;

	modport source (output valid, data, status, count, is_empty, is_full, input ready);
	modport sink (input valid, data, status, count, is_empty, is_full, output ready);
endinterface

// ----- rtl/dq_ram.sv -----
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- rtl/dq_ptr.sv -----
module dq_ptr (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [dq_pkg::OP_FIELD_W-1:0]     op,
	input  logic [dq_pkg::DATA_FIELD_W-1:0]   value,
	input  logic [dq_pkg::POS_FIELD_W-1:0]    position,
	output dq_pkg::mem_req_t                  mreq,
	output dq_pkg::op_res_t                   ores
);
	import dq_pkg::*;

	logic [ADDR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  occ_q, occ_d;
	logic              full, empty;
	logic [OFS_W-1:0]  occ_ofs, back_ofs, pos_ofs, one_ofs;

	assign full     = (occ_q == CNT_W'(DEPTH));
	assign empty    = (occ_q == '0);
	assign occ_ofs  = OFS_W'(occ_q);
	assign back_ofs = OFS_W'(occ_q - CNT_W'(1));
	assign pos_ofs  = OFS_W'(position);
	assign one_ofs  = OFS_W'(1);

	always_comb begin
		head_d       = head_q;
		occ_d        = occ_q;
		mreq.we      = 1'b0;
		mreq.re      = 1'b0;
		mreq.addr    = head_q;
		mreq.wdata   = DATA_WIDTH'(value);
		ores.status  = ST_OK;
		ores.rd      = 1'b0;
		case (op_t'(op))
			OP_PUSH_FRONT: begin
				if (full) begin
					ores.status = ST_FULL;
				end else begin
					head_d    = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - ADDR_W'(1);
					mreq.we   = 1'b1;
					mreq.addr = head_d;
					occ_d     = occ_q + CNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					ores.status = ST_FULL;
				end else begin
					mreq.we   = 1'b1;
					mreq.addr = wrap_add(head_q, occ_ofs);
					occ_d     = occ_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					ores.status = ST_EMPTY;
				end else begin
					mreq.re   = 1'b1;
					mreq.addr = head_q;
					head_d    = wrap_add(head_q, one_ofs);
					occ_d     = occ_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					ores.status = ST_EMPTY;
				end else begin
					mreq.re   = 1'b1;
					mreq.addr = wrap_add(head_q, back_ofs);
					occ_d     = occ_q - CNT_W'(1);
				end
			end
			OP_PEEK_FRONT: begin
				if (empty) begin
					ores.status = ST_EMPTY;
				end else begin
					mreq.re   = 1'b1;
					mreq.addr = head_q;
				end
			end
			OP_PEEK_BACK: begin
				if (empty) begin
					ores.status = ST_EMPTY;
				end else begin
					mreq.re   = 1'b1;
					mreq.addr = wrap_add(head_q, back_ofs);
				end
			end
			OP_READ_AT: begin
				if (pos_ofs >= occ_ofs) begin
					ores.status = ST_EMPTY;
				end else begin
					mreq.re   = 1'b1;
					mreq.addr = wrap_add(head_q, pos_ofs);
				end
			end
			default: begin
			end
		endcase
		mreq.we    = mreq.we & accept;
		mreq.re    = mreq.re & accept;
		ores.rd    = mreq.re;
		ores.count = occ_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (accept) begin
			head_q <= head_d;
			occ_q  <= occ_d;
		end
	end

endmodule

// ----- rtl/double_ended_queue.sv -----
// Channel  Direction  Contents
// req      sink       op, value, position
// rsp      source     data, status, count, is_empty, is_full
//
// One item is accepted per cycle unless a full stage register meets a stalled output.
// Front pointer and count update at acceptance, and at most one store access is issued then.
// Read data is captured in the store's read register, then moves to the output register.
// A stalled output holds one result while a second waits in the stage register.
// Reset clears the pointer, the count and the valid flags; the store is left as it is.
module double_ended_queue (
	input  logic      clk,
	input  logic      arst_n,
	dq_req_if.sink    req,
	dq_rsp_if.source  rsp
);
	import dq_pkg::*;

	logic                    accept, adv_s1;
	mem_req_t                mreq;
	op_res_t                 ores;
	logic [DATA_WIDTH-1:0]   rdata;
	logic                    valid_s1;
	op_res_t                 res_s1;
	logic                    out_v_q;
	op_res_t                 out_res_q;
	logic [DATA_FIELD_W-1:0] out_data_q;

	assign adv_s1    = !out_v_q || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	dq_ptr u_ptr (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.op       (req.op),
		.value    (req.value),
		.position (req.position),
		.mreq     (mreq),
		.ores     (ores)
	);

	dq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mreq.we),
		.re    (mreq.re),
		.addr  (mreq.addr),
		.wdata (mreq.wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && adv_s1) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= ores;
		end
		if (valid_s1 && adv_s1) begin
			out_res_q  <= res_s1;
			out_data_q <= res_s1.rd ? DATA_FIELD_W'(rdata) : '0;
		end
	end

	assign rsp.valid    = out_v_q;
	assign rsp.data     = out_data_q;
	assign rsp.status   = out_res_q.status;
	assign rsp.count    = COUNT_FIELD_W'(out_res_q.count);
	assign rsp.is_empty = (out_res_q.count == '0);
	assign rsp.is_full  = (out_res_q.count == CNT_W'(DEPTH));

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.we && mreq.re))
		else $error("Store written and read by the same item.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (ores.count <= CNT_W'(DEPTH)))
		else $error("Element count exceeds the store depth.");

	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("Accepted item did not reach the stage register.");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_FULL || rsp.status == ST_EMPTY)) |->
		(rsp.data == '0))
		else $error("Failed operation returned non-zero data.");

endmodule
